// ===== rtl/core/segment_sdf_antialias_blend_top_defines.svh =====
// Assertion macros used by the segment shader's checker.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef SEGMENT_SDF_ANTIALIAS_BLEND_TOP_DEFINES_SVH
`define SEGMENT_SDF_ANTIALIAS_BLEND_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SSAB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SSAB_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ssab_pkg.sv =====
// Shared constants for the anti-aliased segment shader.
// No dependencies; used by the top level, the divider and the checker.
package ssab_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int HW_BITS        = 8;
  localparam int COLOR_BITS     = 8;
  // Perpendicular cross products at or above 2**CMAG_BITS are never drawn.
  localparam int CMAG_BITS      = 26;
  localparam int CFG_IDX_BITS   = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_X  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y  = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_X    = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Y    = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_W   = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_STROKE_R = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_STROKE_G = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_STROKE_B = 4'd7;

endpackage

// ===== rtl/core/ssab_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
// Depends on ssab_pkg for the stroke half-width size that bounds the quotient.
module ssab_div #(
  parameter int NUM_W     = 52,
  parameter int REM_W     = 26,
  parameter int FRAC_BITS = 8,
  parameter int TAG_W     = 48
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           en,
  input  logic                                           in_vld,
  input  logic [NUM_W-1:0]                               in_num,
  input  logic [REM_W-1:0]                               in_den,
  input  logic [TAG_W-1:0]                               in_tag,
  output logic                                           out_vld,
  output logic [2*ssab_pkg::HW_BITS+2*FRAC_BITS-1:0]     out_quo,
  output logic [TAG_W-1:0]                               out_tag
);
  import ssab_pkg::*;

  // The numerator is below den * 2**QI, so only the low QI numerator bits
  // need a stage of their own; the rest seed the remainder.
  localparam int QI = 2*HW_BITS;
  localparam int QB = QI + 2*FRAC_BITS;

  logic [QB-1:0]    vld_r;
  logic [REM_W-1:0] rem_r [QB];
  logic [REM_W-1:0] den_r [QB];
  logic [QI-1:0]    nb_r  [QB];
  logic [QB-1:0]    quo_r [QB];
  logic [TAG_W-1:0] tag_r [QB];

  logic [REM_W-1:0] rem_nxt [QB];
  logic [QI-1:0]    nb_nxt  [QB];
  logic [QB-1:0]    quo_nxt [QB];

  always_comb begin : p_step
    logic [REM_W-1:0] rem_c;
    logic [REM_W-1:0] den_c;
    logic [QI-1:0]    nb_c;
    logic [QB-1:0]    quo_c;
    logic [REM_W:0]   trial;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rem_c = REM_W'(in_num >> QI);
        den_c = in_den;
        nb_c  = in_num[QI-1:0];
        quo_c = '0;
      end else begin
        rem_c = rem_r[k-1];
        den_c = den_r[k-1];
        nb_c  = nb_r[k-1];
        quo_c = quo_r[k-1];
      end
      trial = {rem_c, nb_c[QI-1]};
      if (trial >= {1'b0, den_c}) begin
        rem_nxt[k] = REM_W'(trial - {1'b0, den_c});
        quo_nxt[k] = {quo_c[QB-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[REM_W-1:0];
        quo_nxt[k] = {quo_c[QB-2:0], 1'b0};
      end
      nb_nxt[k] = {nb_c[QI-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QB-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        nb_r[k]  <= nb_nxt[k];
        quo_r[k] <= quo_nxt[k];
        if (k == 0) begin
          den_r[k] <= in_den;
          tag_r[k] <= in_tag;
        end else begin
          den_r[k] <= den_r[k-1];
          tag_r[k] <= tag_r[k-1];
        end
      end
    end
  end

  assign out_vld = vld_r[QB-1];
  assign out_quo = quo_r[QB-1];
  assign out_tag = tag_r[QB-1];

endmodule

// ===== rtl/core/ssab_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a tag carried alongside.
// No package dependencies.
module ssab_sqrt #(
  parameter int IN_W  = 32,
  parameter int TAG_W = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_vld,
  output logic [IN_W/2-1:0] out_root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int RT_W = IN_W/2;

  logic [RT_W-1:0]  vld_r;
  logic [RT_W:0]    rem_r  [RT_W];
  logic [RT_W-1:0]  root_r [RT_W];
  logic [IN_W-1:0]  rad_r  [RT_W];
  logic [TAG_W-1:0] tag_r  [RT_W];

  logic [RT_W:0]    rem_nxt  [RT_W];
  logic [RT_W-1:0]  root_nxt [RT_W];
  logic [IN_W-1:0]  rad_nxt  [RT_W];

  always_comb begin : p_step
    logic [RT_W:0]   rem_c;
    logic [RT_W-1:0] root_c;
    logic [IN_W-1:0] rad_c;
    logic [RT_W+2:0] r4;
    logic [RT_W+2:0] trial;
    for (int k = 0; k < RT_W; k++) begin
      if (k == 0) begin
        rem_c  = '0;
        root_c = '0;
        rad_c  = in_rad;
      end else begin
        rem_c  = rem_r[k-1];
        root_c = root_r[k-1];
        rad_c  = rad_r[k-1];
      end
      r4    = {rem_c, rad_c[IN_W-1:IN_W-2]};
      trial = {1'b0, root_c, 2'b01};
      if (r4 >= trial) begin
        rem_nxt[k]  = (RT_W+1)'(r4 - trial);
        root_nxt[k] = {root_c[RT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = r4[RT_W:0];
        root_nxt[k] = {root_c[RT_W-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_c[IN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RT_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RT_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        if (k == 0) begin
          tag_r[k] <= in_tag;
        end else begin
          tag_r[k] <= tag_r[k-1];
        end
      end
    end
  end

  assign out_vld  = vld_r[RT_W-1];
  assign out_root = root_r[RT_W-1];
  assign out_tag  = tag_r[RT_W-1];

endmodule

// ===== rtl/core/segment_sdf_antialias_blend_top.sv =====
// Top level of the anti-aliased segment shader.
// Depends on ssab_pkg, ssab_div and ssab_sqrt.

// Shades one pixel word per clock against a configured line segment. Each
// input word (pixel position and background color) yields one output word
// with the blended color when the pixel lies closer than half_width + 1 to
// the segment, and no word otherwise. The pipeline is fully pipelined: a new
// word is accepted every cycle while the output is free or being taken, and
// a stalled output freezes every stage. The depth is set by the
// bit-per-stage divider (2*(HW_BITS + FRAC_BITS) stages) and square root
// (HW_BITS + FRAC_BITS stages). Configuration words are taken at any time,
// but should be written while no pixel is in flight, and derived segment
// terms then settle through the dx/dy, len2 and lim2len2 registers in turn
// after the last write.
module segment_sdf_antialias_blend_top #(
  parameter int COORD_BITS = ssab_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ssab_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ssab_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         in_pixel_x,
  input  logic signed [COORD_BITS-1:0]         in_pixel_y,
  input  logic [ssab_pkg::COLOR_BITS-1:0]      in_back_red,
  input  logic [ssab_pkg::COLOR_BITS-1:0]      in_back_green,
  input  logic [ssab_pkg::COLOR_BITS-1:0]      in_back_blue,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_BITS-1:0]         out_x,
  output logic signed [COORD_BITS-1:0]         out_y,
  output logic [ssab_pkg::COLOR_BITS-1:0]      out_blend_red,
  output logic [ssab_pkg::COLOR_BITS-1:0]      out_blend_green,
  output logic [ssab_pkg::COLOR_BITS-1:0]      out_blend_blue
);
  import ssab_pkg::*;

  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2*COORD_BITS + 2;
  localparam int SUMW  = 2*COORD_BITS + 3;
  localparam int LW    = 2*COORD_BITS + 2;
  localparam int NW    = (LW > 2*CMAG_BITS) ? LW : 2*CMAG_BITS;
  localparam int LIM2W = 2*HW_BITS + 2;
  localparam int ML    = LW + LIM2W;
  localparam int QB    = 2*HW_BITS + 2*FRAC_BITS;
  localparam int SB    = QB/2;
  localparam int EW    = FRAC_BITS + HW_BITS + 2;
  localparam int AW    = FRAC_BITS + 2;
  localparam int MW    = FRAC_BITS + COLOR_BITS + 3;
  localparam int TW    = 2*COORD_BITS + 3*COLOR_BITS;
  localparam logic [AW-1:0]        A_FULL = AW'(1) << (FRAC_BITS + 1);
  localparam logic signed [EW-1:0] E_FULL = EW'(A_FULL);

  // Configuration registers and terms derived from them.
  logic signed [COORD_BITS-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [HW_BITS-1:0]           half_width_r;
  logic [COLOR_BITS-1:0]        stroke_r_r, stroke_g_r, stroke_b_r;
  logic signed [DW-1:0]         dx_r, dy_r;
  logic signed [PW-1:0]         dxsq, dysq;
  logic [LW-1:0]                len2_r;
  logic [HW_BITS:0]             lim;
  logic [LIM2W-1:0]             lim2_r;
  logic [ML-1:0]                lim2len2_r;

  logic adv;

  // Stage 1: offsets from both end points.
  logic                 v1_r;
  logic signed [DW-1:0] px1_r, py1_r, qx1_r, qy1_r;
  logic [TW-1:0]        t1_r;

  // Stage 2: dot, cross and squared end point distances.
  logic                   v2_r;
  logic signed [PW-1:0]   m_pdx, m_pdy, m_pxdy, m_pydx, m_pxx, m_pyy, m_qxx, m_qyy;
  logic signed [SUMW-1:0] dot2_r, cr2_r;
  logic [LW-1:0]          s0_2_r, s1_2_r;
  logic [TW-1:0]          t2_r;

  // Stage 3: region select and squared cross product.
  logic                     v3_r;
  logic                     endp3_r, big3_r;
  logic [LW-1:0]            s3_r, cmag;
  logic [CMAG_BITS-1:0]     c26;
  logic [2*CMAG_BITS-1:0]   c2_3_r;
  logic                     bef, past, zero_len;
  logic [TW-1:0]            t3_r;

  // Stage 4: distance cut and divider operands.
  logic          v4_r;
  logic          rej;
  logic [NW-1:0] n4_r;
  logic [LW-1:0] l4_r;
  logic [TW-1:0] t4_r;

  logic          dv_vld;
  logic [QB-1:0] dv_quo;
  logic [TW-1:0] dv_tag;
  logic          sq_vld;
  logic [SB-1:0] sq_root;
  logic [TW-1:0] sq_tag;

  // Stage 5: edge distance and alpha.
  logic                 v5_r;
  logic signed [EW-1:0] e_c;
  logic [AW-1:0]        a5_r;
  logic [TW-1:0]        t5_r;

  logic                          out_valid_r;
  logic signed [COORD_BITS-1:0]  out_x_r, out_y_r;
  logic [COLOR_BITS-1:0]         out_r_r, out_g_r, out_b_r;

  function automatic logic [COLOR_BITS-1:0] mix_ch(input logic [COLOR_BITS-1:0] s,
                                                   input logic [COLOR_BITS-1:0] b,
                                                   input logic [AW-1:0] a);
    logic [MW-1:0] m;
    m = MW'(s) * MW'(A_FULL - a) + MW'(b) * MW'(a);
    return m[FRAC_BITS+COLOR_BITS:FRAC_BITS+1];
  endfunction

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      end_x_r      <= '0;
      end_y_r      <= '0;
      half_width_r <= HW_BITS'(1);
      stroke_r_r   <= '0;
      stroke_g_r   <= '0;
      stroke_b_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_X:  start_x_r    <= cfg_data;
        REG_START_Y:  start_y_r    <= cfg_data;
        REG_END_X:    end_x_r      <= cfg_data;
        REG_END_Y:    end_y_r      <= cfg_data;
        REG_HALF_W:   half_width_r <= cfg_data[HW_BITS-1:0];
        REG_STROKE_R: stroke_r_r   <= cfg_data[COLOR_BITS-1:0];
        REG_STROKE_G: stroke_g_r   <= cfg_data[COLOR_BITS-1:0];
        REG_STROKE_B: stroke_b_r   <= cfg_data[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign dxsq = dx_r * dx_r;
  assign dysq = dy_r * dy_r;
  assign lim  = (HW_BITS+1)'(half_width_r) + (HW_BITS+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r       <= '0;
      dy_r       <= '0;
      len2_r     <= '0;
      lim2_r     <= LIM2W'(4);
      lim2len2_r <= '0;
    end else begin
      dx_r       <= DW'(end_x_r) - DW'(start_x_r);
      dy_r       <= DW'(end_y_r) - DW'(start_y_r);
      len2_r     <= LW'(dxsq) + LW'(dysq);
      lim2_r     <= LIM2W'(lim) * LIM2W'(lim);
      lim2len2_r <= ML'(lim2_r) * ML'(len2_r);
    end
  end

  // Stage 2 products.
  assign m_pdx  = px1_r * dx_r;
  assign m_pdy  = py1_r * dy_r;
  assign m_pxdy = px1_r * dy_r;
  assign m_pydx = py1_r * dx_r;
  assign m_pxx  = px1_r * px1_r;
  assign m_pyy  = py1_r * py1_r;
  assign m_qxx  = qx1_r * qx1_r;
  assign m_qyy  = qy1_r * qy1_r;

  // Stage 3 region test: a projection exactly on an end point counts as inside.
  assign zero_len = (len2_r == '0);
  assign bef      = (dot2_r < 0);
  assign past     = (dot2_r > $signed({1'b0, len2_r}));
  assign cmag     = LW'((cr2_r < 0) ? -cr2_r : cr2_r);
  assign c26      = CMAG_BITS'(cmag);

  // Stage 4 cut: end point regions compare squared distances directly.
  assign rej = endp3_r ? (s3_r >= LW'(lim2_r))
                       : (big3_r || (c2_3_r >= NW'(lim2len2_r)));

  // Stage 5: edge distance in FRAC_BITS fraction bits, kept while below two.
  assign e_c = EW'(sq_root) + (EW'(1) << FRAC_BITS) - (EW'(half_width_r) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r && !rej;
      v5_r        <= sq_vld && (e_c < E_FULL);
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r <= DW'(in_pixel_x) - DW'(start_x_r);
      py1_r <= DW'(in_pixel_y) - DW'(start_y_r);
      qx1_r <= DW'(in_pixel_x) - DW'(end_x_r);
      qy1_r <= DW'(in_pixel_y) - DW'(end_y_r);
      t1_r  <= {in_pixel_x, in_pixel_y, in_back_red, in_back_green, in_back_blue};

      dot2_r <= SUMW'(m_pdx) + SUMW'(m_pdy);
      cr2_r  <= SUMW'(m_pxdy) - SUMW'(m_pydx);
      s0_2_r <= LW'(m_pxx) + LW'(m_pyy);
      s1_2_r <= LW'(m_qxx) + LW'(m_qyy);
      t2_r   <= t1_r;

      endp3_r <= zero_len || bef || past;
      s3_r    <= (zero_len || bef) ? s0_2_r : s1_2_r;
      big3_r  <= ((cmag >> CMAG_BITS) != '0);
      c2_3_r  <= c26 * c26;
      t3_r    <= t2_r;

      n4_r <= endp3_r ? NW'(s3_r) : NW'(c2_3_r);
      l4_r <= endp3_r ? LW'(1) : len2_r;
      t4_r <= t3_r;

      a5_r <= (e_c < 0) ? '0 : AW'(e_c);
      t5_r <= sq_tag;

      out_x_r <= t5_r[TW-1 -: COORD_BITS];
      out_y_r <= t5_r[TW-COORD_BITS-1 -: COORD_BITS];
      out_r_r <= mix_ch(stroke_r_r, t5_r[3*COLOR_BITS-1 -: COLOR_BITS], a5_r);
      out_g_r <= mix_ch(stroke_g_r, t5_r[2*COLOR_BITS-1 -: COLOR_BITS], a5_r);
      out_b_r <= mix_ch(stroke_b_r, t5_r[COLOR_BITS-1:0], a5_r);
    end
  end

  ssab_div #(
    .NUM_W     (NW),
    .REM_W     (LW),
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (TW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (v4_r),
    .in_num  (n4_r),
    .in_den  (l4_r),
    .in_tag  (t4_r),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_tag (dv_tag)
  );

  ssab_sqrt #(
    .IN_W  (QB),
    .TAG_W (TW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (dv_vld),
    .in_rad   (dv_quo),
    .in_tag   (dv_tag),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  assign out_valid       = out_valid_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_blend_red   = out_r_r;
  assign out_blend_green = out_g_r;
  assign out_blend_blue  = out_b_r;

endmodule

// ===== rtl/core/ssab_checker.sv =====
// Port-level checks for the segment shader, bound to its top level.
// Depends on ssab_pkg and segment_sdf_antialias_blend_top_defines.svh.
`include "segment_sdf_antialias_blend_top_defines.svh"

module ssab_checker #(
  parameter int COORD_BITS = ssab_pkg::COORD_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [COORD_BITS-1:0]           out_x,
  input logic [COORD_BITS-1:0]           out_y,
  input logic [ssab_pkg::COLOR_BITS-1:0] out_blend_red,
  input logic [ssab_pkg::COLOR_BITS-1:0] out_blend_green,
  input logic [ssab_pkg::COLOR_BITS-1:0] out_blend_blue
);
  import ssab_pkg::*;

  // A word that is not taken stays offered.
  `SSAB_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "output word dropped")
  `SSAB_ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_blend_red) && $stable(out_blend_green) && $stable(out_blend_blue), "stalled output word changed")
  // The whole pipeline moves only when the output register can move.
  `SSAB_ASSERT_CLK(a_in_ready, in_ready == (!out_valid || out_ready), "input ready disagrees with output stall")
  `SSAB_ASSERT_ANY(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind segment_sdf_antialias_blend_top ssab_checker #(.COORD_BITS(COORD_BITS)) u_ssab_checker (.*);
